/* hdl/surface_curvature_descriptors_macros.svh */
// Assertion macros shared by the surface curvature descriptor RTL.
`ifndef SURFACE_CURVATURE_DESCRIPTORS_MACROS_SVH
`define SURFACE_CURVATURE_DESCRIPTORS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/scd_pkg.sv */
// Shared constants, types and tables for the surface curvature descriptor block.
package scd_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = 6;
    localparam int CNT_W        = 7;

    localparam logic [30:0] LOG_SCALE = 31'd1895245374;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [15:0] shape;
        logic        [31:0] cv;
    } t_entry;

    // Arctangent of 2^-i in units where pi/2 equals 2^30.
    function automatic logic [30:0] cordic_atan(input logic [4:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd536870912;
            5'd1:  v = 31'd316933406;
            5'd2:  v = 31'd167458907;
            5'd3:  v = 31'd85004756;
            5'd4:  v = 31'd42667331;
            5'd5:  v = 31'd21354465;
            5'd6:  v = 31'd10679838;
            5'd7:  v = 31'd5340245;
            5'd8:  v = 31'd2670163;
            5'd9:  v = 31'd1335087;
            5'd10: v = 31'd667544;
            5'd11: v = 31'd333772;
            5'd12: v = 31'd166886;
            5'd13: v = 31'd83443;
            5'd14: v = 31'd41722;
            5'd15: v = 31'd20861;
            5'd16: v = 31'd10430;
            5'd17: v = 31'd5215;
            5'd18: v = 31'd2608;
            5'd19: v = 31'd1304;
            5'd20: v = 31'd652;
            5'd21: v = 31'd326;
            5'd22: v = 31'd163;
            5'd23: v = 31'd81;
            5'd24: v = 31'd41;
            5'd25: v = 31'd20;
            5'd26: v = 31'd10;
            5'd27: v = 31'd5;
            5'd28: v = 31'd3;
            5'd29: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat34(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

/* hdl/surface_curvature_descriptors.sv */
// Top level of the surface curvature descriptor block.
//
// Each request carries the mean and Gaussian curvature of one vertex. The
// per-vertex unit runs two 32-step square roots and a 30-step CORDIC that
// runs beside the second root, and the input is stalled while it works. Up
// to 64 vertices are stored in an on-chip memory; more are dropped and
// flagged. The request marked last starts emission of every stored vertex in
// load order. Each result takes a memory read and handoff plus the log unit,
// which finds the leading one, shifts once per leading zero of the curvedness
// (up to 31), runs 24 squaring steps and scales the result. When the log
// saturates, the log unit answers without these steps.
`include "surface_curvature_descriptors_macros.svh"

module surface_curvature_descriptors (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_mean_curv,
    input  logic signed [31:0] i_gauss_curv,
    input  logic               i_last_vertex,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [5:0]         o_vertex_index,
    output logic signed [31:0] o_principal_max,
    output logic signed [31:0] o_principal_min,
    output logic signed [15:0] o_shape_idx,
    output logic signed [23:0] o_curvedness_log,
    output logic               o_overflow_seen,
    output logic               o_last_result
);
    import scd_pkg::*;

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_VERT  = 3'd1;
    localparam logic [2:0] T_RD    = 3'd2;
    localparam logic [2:0] T_LOGGO = 3'd3;
    localparam logic [2:0] T_LOGW  = 3'd4;
    localparam logic [2:0] T_OUT   = 3'd5;

    t_entry r_mem [MAX_VERTICES];

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_idx;
    logic [31:0]       r_min;
    logic              r_dropped;
    logic              r_last;
    t_entry            r_rd;
    logic              r_out_valid;
    logic [5:0]        r_o_index;
    logic [31:0]       r_o_k1, r_o_k2;
    logic [15:0]       r_o_shape;
    logic [23:0]       r_o_log;
    logic              r_o_ovf, r_o_last;

    logic              w_acc, w_vstart, w_vdone, w_lstart, w_ldone, w_we;
    t_entry            w_ventry;
    logic [31:0]       w_curv;
    logic signed [23:0] w_log;
    logic [CNT_W-1:0]  w_next_idx;

    assign o_in_stall = (r_state != T_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_vstart   = w_acc && (r_count < CNT_W'(MAX_VERTICES));
    assign w_we       = (r_state == T_VERT) && w_vdone;
    assign w_lstart   = (r_state == T_LOGGO);
    assign w_curv     = (r_rd.cv == 32'd0) ? r_min : r_rd.cv;
    assign w_next_idx = {1'b0, r_idx} + 7'd1;

    scd_vertex u_vertex (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_vstart),
        .i_mean_curv  (i_mean_curv),
        .i_gauss_curv (i_gauss_curv),
        .o_done       (w_vdone),
        .o_entry      (w_ventry)
    );

    scd_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lstart),
        .i_curv  (w_curv),
        .o_done  (w_ldone),
        .o_log   (w_log)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= w_ventry;
        end
        if (r_state == T_RD) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_min       <= 32'hFFFF_FFFF;
            r_dropped   <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (w_acc) begin
                        r_last <= i_last_vertex;
                        if (w_vstart) begin
                            r_state <= T_VERT;
                        end else begin
                            r_dropped <= 1'b1;
                            if (i_last_vertex) begin
                                // A full store is never empty, so emission starts.
                                r_idx   <= '0;
                                r_state <= T_RD;
                            end
                        end
                    end
                end
                T_VERT: begin
                    if (w_vdone) begin
                        r_count <= r_count + 7'd1;
                        if (w_ventry.cv != 32'd0 && w_ventry.cv < r_min) begin
                            r_min <= w_ventry.cv;
                        end
                        r_idx   <= '0;
                        r_state <= r_last ? T_RD : T_IDLE;
                    end
                end
                T_RD:    r_state <= T_LOGGO;
                T_LOGGO: r_state <= T_LOGW;
                T_LOGW: begin
                    if (w_ldone) begin
                        r_out_valid <= 1'b1;
                        r_state     <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_o_last) begin
                            r_count   <= '0;
                            r_min     <= 32'hFFFF_FFFF;
                            r_dropped <= 1'b0;
                            r_state   <= T_IDLE;
                        end else begin
                            r_idx   <= w_next_idx[ADDR_W-1:0];
                            r_state <= T_RD;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_LOGW && w_ldone) begin
            r_o_index <= r_idx;
            r_o_k1    <= r_rd.k1;
            r_o_k2    <= r_rd.k2;
            r_o_shape <= r_rd.shape;
            r_o_log   <= w_log;
            r_o_ovf   <= r_dropped;
            r_o_last  <= (w_next_idx == r_count);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_vertex_index   = r_o_index;
    assign o_principal_max  = r_o_k1;
    assign o_principal_min  = r_o_k2;
    assign o_shape_idx      = r_o_shape;
    assign o_curvedness_log = r_o_log;
    assign o_overflow_seen  = r_o_ovf;
    assign o_last_result    = r_o_last;

    `SCD_ASSERT_IMPL(a_idle_no_result, !o_in_stall, !o_out_valid, "result pending while idle")
    `SCD_ASSERT_IMPL(a_count_cap, 1'b1, r_count <= CNT_W'(MAX_VERTICES), "vertex count over capacity")
    `SCD_ASSERT_IMPL(a_vdone_state, w_vdone, r_state == T_VERT, "vertex unit done outside compute")
    `SCD_ASSERT_NEXT(a_set_cleared, o_out_valid && !i_out_stall && o_last_result, r_count == '0, "set not cleared after last result")

endmodule

/* hdl/scd_vertex.sv */
// Per-vertex unit: principal curvatures, raw curvedness and shape index.
module scd_vertex (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_mean_curv,
    input  logic signed [31:0] i_gauss_curv,
    output logic               o_done,
    output scd_pkg::t_entry    o_entry
);
    import scd_pkg::*;

    localparam logic [3:0] V_IDLE = 4'd0;
    localparam logic [3:0] V_SQH  = 4'd1;
    localparam logic [3:0] V_DISC = 4'd2;
    localparam logic [3:0] V_SQRT = 4'd3;
    localparam logic [3:0] V_K    = 4'd4;
    localparam logic [3:0] V_SQ1  = 4'd5;
    localparam logic [3:0] V_SQ2  = 4'd6;
    localparam logic [3:0] V_SQ3  = 4'd7;
    localparam logic [3:0] V_ITER = 4'd8;

    localparam logic [63:0] BIT_INIT = 64'h4000_0000_0000_0000;

    logic [3:0]         r_state;
    logic [4:0]         r_cnt;
    logic signed [31:0] r_h, r_k, r_k1, r_k2;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc, r_rem, r_root, r_bit;
    logic signed [36:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic               r_neg;
    logic               r_done;
    t_entry             r_entry;

    logic signed [31:0] w_mul_a;
    logic signed [63:0] w_prod;
    logic [63:0]        w_trial, s_rem, s_root, s_bit;
    logic signed [63:0] w_disc;
    logic [33:0]        w_hp, w_hm, w_d, w_s, w_sabs;
    logic [63:0]        w_sq;
    logic signed [36:0] w_xs, w_ys;
    logic signed [33:0] w_ang;
    logic [31:0]        w_zc;
    logic [31:0]        w_qsum;
    logic [15:0]        w_q, w_shape;

    // Single shared squarer.
    always_comb begin
        case (r_state)
            V_SQ1:   w_mul_a = r_k1;
            V_SQ2:   w_mul_a = r_k2;
            default: w_mul_a = r_h;
        endcase
    end
    assign w_prod = w_mul_a * w_mul_a;

    // One restoring square root step, used for delta and for curvedness.
    always_comb begin
        w_trial = r_root + r_bit;
        if (r_rem >= w_trial) begin
            s_rem  = r_rem - w_trial;
            s_root = (r_root >> 1) + r_bit;
        end else begin
            s_rem  = r_rem;
            s_root = r_root >> 1;
        end
        s_bit = r_bit >> 2;
    end

    assign w_disc = r_prod - {{16{r_k[31]}}, r_k, 16'b0};
    assign w_hp   = {{2{r_h[31]}}, r_h} + {2'b00, r_root[31:0]};
    assign w_hm   = {{2{r_h[31]}}, r_h} - {2'b00, r_root[31:0]};
    assign w_d    = {{2{r_k1[31]}}, r_k1} - {{2{r_k2[31]}}, r_k2};
    assign w_s    = {{2{r_k1[31]}}, r_k1} + {{2{r_k2[31]}}, r_k2};
    assign w_sabs = w_s[33] ? (34'd0 - w_s) : w_s;
    assign w_sq   = r_acc + r_prod;
    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_ang  = $signed({3'b000, cordic_atan(r_cnt)});

    // Angle clamped to [0, pi/2] and rounded to Q1.14.
    always_comb begin
        if (r_z[33]) begin
            w_zc = 32'd0;
        end else if (r_z > 34'sd1073741824) begin
            w_zc = 32'd1073741824;
        end else begin
            w_zc = r_z[31:0];
        end
        w_qsum = w_zc + 32'd32768;
        w_q    = w_qsum[31:16];
        if (r_k1 == r_k2) begin
            w_shape = r_k1[31] ? 16'd16384 : 16'hC000;
        end else begin
            w_shape = r_neg ? w_q : (16'd0 - w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                V_IDLE: if (i_start) r_state <= V_SQH;
                V_SQH:  r_state <= V_DISC;
                V_DISC: r_state <= V_SQRT;
                V_SQRT: if (r_cnt == 5'd31) r_state <= V_K;
                V_K:    r_state <= V_SQ1;
                V_SQ1:  r_state <= V_SQ2;
                V_SQ2:  r_state <= V_SQ3;
                V_SQ3:  r_state <= V_ITER;
                V_ITER: begin
                    if (r_cnt == 5'd31) begin
                        r_state <= V_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= V_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            V_IDLE: begin
                if (i_start) begin
                    r_h <= i_mean_curv;
                    r_k <= i_gauss_curv;
                end
            end
            V_SQH: r_prod <= w_prod;
            V_DISC: begin
                r_rem  <= (w_disc > 64'sd0) ? w_disc : 64'd0;
                r_root <= 64'd0;
                r_bit  <= BIT_INIT;
                r_cnt  <= 5'd0;
            end
            V_SQRT: begin
                r_rem  <= s_rem;
                r_root <= s_root;
                r_bit  <= s_bit;
                r_cnt  <= r_cnt + 5'd1;
            end
            V_K: begin
                r_k1 <= sat34(w_hp);
                r_k2 <= sat34(w_hm);
            end
            V_SQ1: begin
                r_prod <= w_prod;
                r_neg  <= w_s[33];
                r_x    <= {{3{w_d[33]}}, w_d};
                r_y    <= {{3{w_sabs[33]}}, w_sabs};
                r_z    <= 34'sd0;
            end
            V_SQ2: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            V_SQ3: begin
                r_rem  <= {1'b0, w_sq[63:1]};
                r_root <= 64'd0;
                r_bit  <= BIT_INIT;
                r_cnt  <= 5'd0;
            end
            V_ITER: begin
                r_rem  <= s_rem;
                r_root <= s_root;
                r_bit  <= s_bit;
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt < 5'd30) begin
                    if (r_y > 37'sd0) begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_ang;
                    end else begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_ang;
                    end
                end
                if (r_cnt == 5'd31) begin
                    r_entry.k1    <= r_k1;
                    r_entry.k2    <= r_k2;
                    r_entry.shape <= w_shape;
                    r_entry.cv    <= s_root[31:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_entry = r_entry;

endmodule

/* hdl/scd_log.sv */
// Scaled natural log unit: (2/pi)*ln(c) in Q7.16 by repeated squaring.
module scd_log (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_curv,
    output logic               o_done,
    output logic signed [23:0] o_log
);
    import scd_pkg::*;

    localparam logic [2:0] L_IDLE  = 3'd0;
    localparam logic [2:0] L_NORM  = 3'd1;
    localparam logic [2:0] L_SQ    = 3'd2;
    localparam logic [2:0] L_ADJ   = 3'd3;
    localparam logic [2:0] L_SCALE = 3'd4;
    localparam logic [2:0] L_FIN   = 3'd5;

    logic [2:0]  r_state;
    logic [4:0]  r_cnt, r_p;
    logic [31:0] r_m;
    logic [23:0] r_frac;
    logic [63:0] r_prod;
    logic        r_neg;
    logic        r_done;
    logic [23:0] r_log;

    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_prod;
    logic [32:0] w_t;
    logic [5:0]  w_e;
    logic [29:0] w_l2, w_mag;
    logic [63:0] w_rnd;
    logic [23:0] w_res;

    assign w_mul_a = (r_state == L_SCALE) ? {2'b00, w_mag} : r_m;
    assign w_mul_b = (r_state == L_SCALE) ? {1'b0, LOG_SCALE} : r_m;
    assign w_prod  = w_mul_a * w_mul_b;

    assign w_t   = r_prod[63:31];
    assign w_e   = {1'b0, r_p} - 6'd16;
    assign w_l2  = {w_e, r_frac};
    assign w_mag = w_l2[29] ? (30'd0 - w_l2) : w_l2;
    assign w_rnd = r_prod + 64'h0000_0080_0000_0000;

    always_comb begin
        if (r_neg) begin
            w_res = (w_rnd[63:40] > 24'd8388608) ? 24'h80_0000 : (24'd0 - w_rnd[63:40]);
        end else begin
            w_res = (w_rnd[63:40] > 24'd8388607) ? 24'h7F_FFFF : w_rnd[63:40];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        if (i_curv == 32'hFFFF_FFFF) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM:  if (r_m[31]) r_state <= L_SQ;
                L_SQ:    r_state <= L_ADJ;
                L_ADJ:   r_state <= (r_cnt == 5'd23) ? L_SCALE : L_SQ;
                L_SCALE: r_state <= L_FIN;
                L_FIN: begin
                    r_state <= L_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_m   <= (i_curv == 32'd0) ? 32'd1 : i_curv;
                    r_p   <= 5'd31;
                    r_log <= 24'h7F_FFFF;
                end
            end
            L_NORM: begin
                if (r_m[31]) begin
                    r_frac <= 24'd0;
                    r_cnt  <= 5'd0;
                end else begin
                    r_m <= r_m << 1;
                    r_p <= r_p - 5'd1;
                end
            end
            L_SQ: r_prod <= w_prod;
            L_ADJ: begin
                // Squaring doubles log2; an overflow past 2.0 yields a fraction bit.
                r_frac <= {r_frac[22:0], w_t[32]};
                r_m    <= w_t[32] ? w_t[32:1] : w_t[31:0];
                r_cnt  <= r_cnt + 5'd1;
            end
            L_SCALE: begin
                r_prod <= w_prod;
                r_neg  <= w_l2[29];
            end
            L_FIN: r_log <= w_res;
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_log  = r_log;

endmodule
